@@ hdl/oli_pkg.sv @@
`default_nettype none
package oli_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int OCNT_W   = 6;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_POS  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_INSERT = 1'b1
    } t_kind;

    // Broadcast from the control logic to every cell of the list.
    typedef struct packed {
        logic             cmp_en;
        logic             shift_en;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic             present;
        logic [IDX_W-1:0] found;
        logic [CNT_W-1:0] place;
    } t_ctrl;

endpackage
`default_nettype wire

@@ hdl/oli_cell.sv @@
`default_nettype none
module oli_cell
    import oli_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [KEY_W-1:0] i_prev,
    input  wire logic [KEY_W-1:0] i_next,
    output logic      [KEY_W-1:0] o_entry,
    output logic                  o_match
);

    logic [KEY_W-1:0] r_entry;
    logic [KEY_W-1:0] n_entry;
    logic             r_match;
    logic [CNT_W-1:0] w_idx;
    logic [CNT_W-1:0] w_found;
    logic [KEY_W-1:0] w_rem_here;
    logic [KEY_W-1:0] w_rem_prev;

    assign w_idx   = CNT_W'(i_index);
    assign w_found = CNT_W'(i_ctrl.found);

    // Contents after removing the matched entry, seen at this slot and the one below.
    assign w_rem_here = (i_ctrl.present && (w_idx >= w_found)) ? i_next : r_entry;
    assign w_rem_prev = (i_ctrl.present && (w_idx > w_found)) ? r_entry : i_prev;

    always_comb begin
        if (w_idx < i_ctrl.place) begin
            n_entry = w_rem_here;
        end else if (w_idx == i_ctrl.place) begin
            n_entry = i_ctrl.key;
        end else begin
            n_entry = w_rem_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= (r_entry == i_ctrl.key) && (w_idx < i_ctrl.count);
        end
        if (i_ctrl.shift_en) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
`default_nettype wire

@@ hdl/ordered_list_insert_dedup.sv @@
// The cells register the compare when a transaction is accepted; the shift (if the status is
// done) and the result register follow once no held result blocks them; input then opens again.
// The input is not ready during the shift cycle, nor while the shift waits on a held result.
// Reset (synchronous, active low) empties the list and drops any pending result.
// Entry storage has no reset; only slots below the count are ever used.
`default_nettype none
module ordered_list_insert_dedup
    import oli_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_kind,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [POS_W-1:0]  i_position,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [1:0]        o_status,
    output logic                   o_was_present,
    output logic      [OCNT_W-1:0] o_entry_count
);

    logic [CNT_W-1:0]  r_count;
    logic              r_busy;
    logic [KEY_W-1:0]  r_key;
    t_kind             r_kind;
    logic [POS_W-1:0]  r_pos;
    t_status           r_stat;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_present;
    logic [CNT_W-1:0]  r_out_count;

    logic              w_accept;
    logic              w_step;
    t_status           w_stat;
    t_ctrl             w_ctrl;
    logic              w_present;
    logic [IDX_W-1:0]  w_found;
    logic [CNT_W-1:0]  w_cnt_rm;
    logic [CNT_W-1:0]  w_place;
    logic [CAPACITY-1:0] w_match;
    logic [KEY_W-1:0]  w_entry [CAPACITY];

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_step     = r_busy && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_count == CNT_W'(CAPACITY)) begin
            w_stat = ST_FULL;
        end else if ((t_kind'(i_kind) == KIND_INSERT)
                     && (CMP_W'(i_position) > CMP_W'(r_count))) begin
            w_stat = ST_POS;
        end else begin
            w_stat = ST_DONE;
        end
    end

    assign w_present = |w_match;

    always_comb begin
        w_found = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (w_match[j]) begin
                w_found = w_found | IDX_W'(j);
            end
        end
    end

    assign w_cnt_rm = r_count - CNT_W'(w_present);

    always_comb begin
        if ((r_kind == KIND_INSERT) && (CMP_W'(r_pos) <= CMP_W'(w_cnt_rm))) begin
            w_place = CNT_W'(r_pos);
        end else begin
            w_place = w_cnt_rm;
        end
    end

    always_comb begin
        w_ctrl.cmp_en   = w_accept;
        w_ctrl.shift_en = w_step && (r_stat == ST_DONE);
        w_ctrl.key      = r_busy ? r_key : i_key;
        w_ctrl.count    = r_count;
        w_ctrl.present  = w_present;
        w_ctrl.found    = w_found;
        w_ctrl.place    = w_place;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_prev;
        logic [KEY_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_entry[g];
        end else begin : g_mid_lo
            assign w_prev = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid_hi
            assign w_next = w_entry[g+1];
        end

        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (IDX_W'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_key  <= i_key;
                r_kind <= t_kind'(i_kind);
                r_pos  <= i_position;
                r_stat <= w_stat;
            end
            if (w_step) begin
                r_busy        <= 1'b0;
                r_out_valid   <= 1'b1;
                r_out_status  <= r_stat;
                if (r_stat == ST_DONE) begin
                    r_count       <= w_cnt_rm + CNT_W'(1);
                    r_out_count   <= w_cnt_rm + CNT_W'(1);
                    r_out_present <= w_present;
                end else begin
                    r_out_count   <= r_count;
                    r_out_present <= 1'b0;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_was_present = r_out_present;
    assign o_entry_count = OCNT_W'(r_out_count);

endmodule
`default_nettype wire

@@ hdl/oli_checker.sv @@
`default_nettype none
module oli_checker
    import oli_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [1:0]        o_status,
    input wire logic              o_was_present,
    input wire logic [OCNT_W-1:0] o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_was_present) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken during shift");

    a_err_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DONE) |-> !o_was_present)
        else $error("rejected transaction flagged as present");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_entry_count == OCNT_W'(CAPACITY))
        else $error("full rejection with short list");

    a_done_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_DONE) && (CAPACITY < 64) |-> o_entry_count != '0)
        else $error("completed transaction left list empty");

endmodule

bind ordered_list_insert_dedup oli_checker u_oli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_was_present (o_was_present),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
